FILE: design/bia_pkg.sv
`default_nettype none

package bia_pkg;

   localparam int unsigned ID_W            = 8;
   localparam int unsigned LIMIT_W         = 9;
   localparam int unsigned WORD_BITS       = 32;
   localparam int unsigned BIT_W           = 5;
   localparam int unsigned ID_SPACE        = 256;
   localparam int unsigned NUM_IDS_DEFAULT = 256;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 9'd256;
   localparam logic [WORD_BITS-1:0] WORD_ONES   = 32'hFFFF_FFFF;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_REJECT  = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [ID_W-1:0]   id;
   } job_type;

   typedef struct packed {
      logic               clear;
      logic [LIMIT_W-1:0] eff_limit;
   } ctrl_type;

   // index of the lowest set bit; zero when none is set
   function automatic logic [BIT_W-1:0] lowest_index(input logic [WORD_BITS-1:0] bits);
      logic [WORD_BITS-1:0] onehot;
      logic [BIT_W-1:0]     idx;
      onehot = bits & (~bits + WORD_BITS'(1));
      idx    = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         for (int b = 0; b < BIT_W; b++) begin
            if (((i >> b) & 1) != 0) begin
               idx[b] = idx[b] | onehot[i];
            end
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: design/bia_if.sv
`default_nettype none

interface bia_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [bia_pkg::ID_W-1:0]   release_id;
   modport source (output valid, command, release_id, input ready);
   modport sink   (input valid, command, release_id, output ready);
endinterface

interface bia_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       ok;
   logic [bia_pkg::ID_W-1:0]   id;
   modport source (output valid, ok, id, input ready);
   modport sink   (input valid, ok, id, output ready);
endinterface

interface bia_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bia_pkg::LIMIT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: design/bia_front.sv
`default_nettype none

module bia_front #(
   parameter int unsigned NUM_IDS = bia_pkg::NUM_IDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   bia_req_if.sink            req_ch,
   bia_csr_if.sink            csr_ch,
   output logic               push_valid,
   output bia_pkg::job_type   push_job,
   input  logic               push_ready,
   output bia_pkg::ctrl_type  ctrl
);
   import bia_pkg::*;

   localparam int unsigned CapInt = (NUM_IDS < ID_SPACE) ? NUM_IDS : ID_SPACE;
   localparam logic [LIMIT_W-1:0] Cap = LIMIT_W'(CapInt);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic [LIMIT_W-1:0] eff_limit;

   assign csr_ch.ready = 1'b1;
   assign limit_in     = csr_ch.valid ? csr_ch.data : limit_ff;
   assign eff_limit    = (limit_ff < Cap) ? limit_ff : Cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign ctrl.clear     = csr_ch.valid;
   assign ctrl.eff_limit = eff_limit;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;

   // out-of-range releases are settled here and never touch the map
   always_comb begin
      push_job.id = req_ch.release_id;
      unique case (req_ch.command)
         CMD_ALLOC: begin
            push_job.kind = OP_ALLOC;
         end
         CMD_RELEASE: begin
            push_job.kind = ({1'b0, req_ch.release_id} < eff_limit) ? OP_RELEASE : OP_REJECT;
         end
         default: begin
            push_job.kind = OP_REJECT;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/bia_queue.sv
`default_nettype none

module bia_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  bia_pkg::job_type   push_job,
   output logic               push_ready,
   output logic               pop_valid,
   output bia_pkg::job_type   pop_job,
   input  logic               pop
);
   import bia_pkg::*;

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff;
   logic [PtrW-1:0] wr_in;
   logic [PtrW-1:0] rd_ff;
   logic [PtrW-1:0] rd_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: design/bia_back.sv
`default_nettype none

module bia_back #(
   parameter int unsigned NUM_IDS = bia_pkg::NUM_IDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  bia_pkg::ctrl_type  ctrl,
   input  logic               pop_valid,
   input  bia_pkg::job_type   pop_job,
   output logic               pop,
   bia_rsp_if.source          rsp_ch
);
   import bia_pkg::*;

   localparam int unsigned CapInt   = (NUM_IDS < ID_SPACE) ? NUM_IDS : ID_SPACE;
   localparam int unsigned MapWords = (CapInt + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WordW    = (MapWords > 1) ? $clog2(MapWords) : 1;
   localparam int unsigned HiW      = LIMIT_W - BIT_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   job_type               job_ff;
   job_type               job_in;
   logic [WordW-1:0]      wcnt_ff;
   logic [WordW-1:0]      wcnt_in;
   logic [WORD_BITS-1:0]  map_ff [MapWords];
   logic [WORD_BITS-1:0]  map_in;
   logic                  map_we;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_ok_ff;
   logic                  rsp_ok_in;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [ID_W-1:0]       rsp_id_in;

   logic [WORD_BITS-1:0]  word;
   logic [WORD_BITS-1:0]  mask;
   logic [WORD_BITS-1:0]  free;
   logic [BIT_W-1:0]      free_idx;
   logic [BIT_W-1:0]      bit_sel;
   logic                  found;
   logic                  rel_hit;
   logic [HiW-1:0]        lim_hi;
   logic [BIT_W-1:0]      lim_lo;
   logic [HiW-1:0]        w_ext;
   logic [LIMIT_W-1:0]    lim_m1;
   logic [WordW-1:0]      last_word;
   logic                  lim_zero;
   logic                  is_last;
   logic                  out_free;

   assign word     = map_ff[wcnt_ff];
   assign bit_sel  = job_ff.id[BIT_W-1:0];
   assign rel_hit  = word[bit_sel];
   assign lim_hi   = ctrl.eff_limit[LIMIT_W-1:BIT_W];
   assign lim_lo   = ctrl.eff_limit[BIT_W-1:0];
   assign w_ext    = HiW'(wcnt_ff);
   assign lim_m1   = ctrl.eff_limit - LIMIT_W'(1);
   assign last_word = lim_m1[BIT_W +: WordW];
   assign lim_zero = (ctrl.eff_limit == '0);
   assign is_last  = lim_zero || (wcnt_ff == last_word);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // bits of this word that lie below the limit
   always_comb begin
      if (w_ext < lim_hi) begin
         mask = WORD_ONES;
      end else if (w_ext == lim_hi) begin
         mask = ~(WORD_ONES << lim_lo);
      end else begin
         mask = '0;
      end
   end

   assign free     = ~word & mask;
   assign found    = |free;
   assign free_idx = lowest_index(free);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      wcnt_in      = wcnt_ff;
      pop          = 1'b0;
      map_we       = 1'b0;
      map_in       = word;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_id_in    = rsp_id_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               job_in   = pop_job;
               state_in = ST_WORK;
               wcnt_in  = (pop_job.kind == OP_RELEASE) ? pop_job.id[BIT_W +: WordW] : '0;
            end
         end
         ST_WORK: begin
            unique case (job_ff.kind)
               OP_ALLOC: begin
                  if (found) begin
                     if (out_free) begin
                        map_we       = 1'b1;
                        map_in       = word | (WORD_BITS'(1) << free_idx);
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b1;
                        rsp_id_in    = ID_W'({wcnt_ff, free_idx});
                        state_in     = ST_IDLE;
                     end
                  end else if (is_last) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b0;
                        rsp_id_in    = '0;
                        state_in     = ST_IDLE;
                     end
                  end else begin
                     wcnt_in = wcnt_ff + WordW'(1);
                  end
               end
               OP_RELEASE: begin
                  if (out_free) begin
                     map_we       = rel_hit;
                     map_in       = word & ~(WORD_BITS'(1) << bit_sel);
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = rel_hit;
                     rsp_id_in    = '0;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_id_in    = '0;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      wcnt_ff   <= wcnt_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_id_ff <= rsp_id_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < MapWords; i++) begin
            map_ff[i] <= '0;
         end
      end else if (map_we) begin
         map_ff[wcnt_ff] <= map_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.ok    = rsp_ok_ff;
   assign rsp_ch.id    = rsp_id_ff;

   a_fail_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_id_ff == '0))
      else $error("failed word carries non-zero id");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORK && job_ff.kind == OP_ALLOC && !lim_zero) |-> (wcnt_ff <= last_word))
      else $error("scan ran past the limit");

   a_alloc_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORK && job_ff.kind == OP_ALLOC && found)
      |-> (LIMIT_W'({wcnt_ff, free_idx}) < ctrl.eff_limit))
      else $error("free bit found at or above the limit");

   a_clear_map: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.clear) |-> (map_ff[0] == '0))
      else $error("map not cleared by limit write");

endmodule

`default_nettype wire

FILE: design/bitmap_id_allocator_top.sv
`default_nettype none

// Release: the word passes the queue, then the back end checks one map word; allocate
//   scans the 32-bit map words, one per cycle, up to 8, until a free bit below the limit.
// Throughput: the back end takes no new item until it has answered the last one;
//   a 2-entry queue decouples input.
// Reset: map all free, limit 256, queue and result register empty.
//   A limit write clears the whole map.
module bitmap_id_allocator_top #(
   parameter int unsigned NUM_IDS = bia_pkg::NUM_IDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bia_req_if.sink     req_ch,
   bia_rsp_if.source   rsp_ch,
   bia_csr_if.sink     csr_ch
);
   import bia_pkg::*;

   logic     push_valid;
   job_type  push_job;
   logic     push_ready;
   logic     pop_valid;
   job_type  pop_job;
   logic     pop;
   ctrl_type ctrl;

   bia_front #(
      .NUM_IDS (NUM_IDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .ctrl       (ctrl)
   );

   bia_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   bia_back #(
      .NUM_IDS (NUM_IDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: bench/bitmap_id_allocator_checker.sv
`default_nettype none

module bitmap_id_allocator_checker #(
   parameter int unsigned NUM_IDS = bia_pkg::NUM_IDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bia_req_if          req_mon,
   bia_rsp_if          rsp_mon,
   bia_csr_if          csr_mon,
   output int unsigned fail_count,
   output int unsigned pending
);

   import bia_pkg::*;

   typedef struct packed {
      logic            ok;
      logic [ID_W-1:0] id;
   } grant_type;

   logic [ID_SPACE-1:0] id_map;
   logic [LIMIT_W-1:0]  id_limit;
   grant_type           grant_q[$];
   int unsigned         errors = 0;

   // first-fit scan below the effective limit, or release of one id
   function automatic grant_type grant_for(input logic cmd, input logic [ID_W-1:0] rel);
      int unsigned span;
      grant_type   g;
      span = 32'(id_limit);
      if (span > NUM_IDS) span = NUM_IDS;
      if (span > ID_SPACE) span = ID_SPACE;
      g = '0;
      if (cmd == CMD_ALLOC) begin
         for (int unsigned c = 0; c < span; c++) begin
            if (!id_map[c]) begin
               id_map[c] = 1'b1;
               g.ok      = 1'b1;
               g.id      = ID_W'(c);
               break;
            end
         end
      end else if (rel < span && id_map[rel]) begin
         id_map[rel] = 1'b0;
         g.ok        = 1'b1;
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      grant_type got;
      if (reset) begin
         id_map   = '0;
         id_limit = LIMIT_RESET;
         grant_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            id_limit = csr_mon.data;
            id_map   = '0;
         end
         if (req_mon.valid && req_mon.ready)
            grant_q.push_back(grant_for(req_mon.command, req_mon.release_id));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.ok = rsp_mon.ok;
            got.id = rsp_mon.id;
            if (grant_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result word: ok=%0b id=%0d", got.ok, got.id);
            end else begin
               want = grant_q.pop_front();
               if (got.ok !== want.ok || got.id !== want.id) begin
                  errors++;
                  if (errors <= 10)
                     $display("result mismatch: expected ok=%0b id=%0d, got ok=%0b id=%0d",
                              want.ok, want.id, got.ok, got.id);
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= grant_q.size();
   end

endmodule

`default_nettype wire

FILE: bench/bitmap_id_allocator_top_tb.sv
`default_nettype none

module bitmap_id_allocator_top_tb;

   import bia_pkg::*;

   localparam int unsigned NUM_IDS     = NUM_IDS_DEFAULT;
   localparam int unsigned HOLD_CYCLES = 120;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   bit          idle_on = 1'b1;
   bit          hold_req = 1'b0;
   int unsigned fail_count;
   int unsigned pending;

   bia_req_if req_ch ();
   bia_rsp_if rsp_ch ();
   bia_csr_if csr_ch ();

   bitmap_id_allocator_top #(.NUM_IDS(NUM_IDS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bitmap_id_allocator_checker #(.NUM_IDS(NUM_IDS)) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 500000);
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls, plus one long hold on request
   initial begin
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req && !held) begin
            rsp_ch.ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            held = 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic cmd, input logic [ID_W-1:0] rel);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.release_id <= rel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // mostly ids near the live range, sometimes anything
   function automatic logic [ID_W-1:0] pick_id(input int unsigned span);
      if (span != 0 && $urandom_range(0, 3) != 0)
         return ID_W'($urandom_range(0, (span < ID_SPACE) ? span : ID_SPACE - 1));
      return ID_W'($urandom);
   endfunction

   initial begin
      int unsigned limits[10];
      int unsigned lim;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= CMD_ALLOC;
      req_ch.release_id <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.data       <= '0;
      reset             <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limit: lowest free, double release, release of free id
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_ALLOC, 8'hFF);
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_RELEASE, 8'd1);
      send_word(CMD_RELEASE, 8'd1);
      send_word(CMD_ALLOC, 8'h55);
      send_word(CMD_RELEASE, 8'hFF);
      send_word(CMD_RELEASE, 8'h00);
      send_word(CMD_ALLOC, 8'hFF);
      // limit zero: nothing allocatable
      write_limit(9'd0);
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_RELEASE, 8'h00);
      send_word(CMD_RELEASE, 8'hFF);
      // limit one, out-of-range release
      write_limit(9'd1);
      send_word(CMD_ALLOC, 8'hAA);
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_RELEASE, 8'd1);
      send_word(CMD_RELEASE, 8'd0);
      send_word(CMD_ALLOC, 8'h00);
      // same value again still clears the map
      write_limit(9'd1);
      send_word(CMD_RELEASE, 8'd0);
      send_word(CMD_ALLOC, 8'h00);
      write_limit(9'd256);
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_RELEASE, 8'hFF);

      limits    = '{256, 5, 33, 0, 128, 255, 1, 64, 0, 256};
      limits[8] = $urandom_range(0, 256);
      for (int p = 0; p < 10; p++) begin
         lim     = limits[p];
         idle_on = (p != 9);
         write_limit(LIMIT_W'(lim));
         // fill past full, a few releases mixed in
         for (int k = 0; k < lim + 2; k++) begin
            if ($urandom_range(0, 7) == 0)
               send_word(CMD_RELEASE, pick_id(lim));
            else
               send_word(CMD_ALLOC, ID_W'($urandom));
         end
         for (int k = 0; k < 60; k++) begin
            if (p == 1 && k == 10) hold_req = 1'b1;
            if ($urandom_range(0, 1) == 0)
               send_word(CMD_ALLOC, ID_W'($urandom));
            else
               send_word(CMD_RELEASE, pick_id(lim));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
